>>> rtl/bfg_pkg.sv
// bfg_pkg: widths, payload and control structs, register codes and constant
// tables (discharge curve, cell-count reciprocals) for the battery fuel gauge.
// No dependencies; every module under rtl/ refers to it by scoped names.
package bfg_pkg;

  // Field widths
  localparam int RAW_W      = 12;
  localparam int VOLT_W     = 21;   // voltage in 1/16 mV
  localparam int MV_W       = 17;
  localparam int PCT_W      = 7;
  localparam int CELL_W     = 5;
  localparam int SCALE_W    = 24;
  localparam int RATIO_W    = 16;
  localparam int CAL_W      = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Discharge curve
  localparam int CURVE_POINTS = 21;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int CURVE_V_W    = 17;
  localparam int DV_W         = 13;   // widest segment is 4960
  localparam int Q_W          = 3;    // quotient never exceeds the 5 % step

  // Shared multiply-add unit
  localparam int MAC_A_W = 28;
  localparam int MAC_B_W = 16;
  localparam int ACC_W   = 52;

  // Reciprocals: floor(n/10) = (n * DIV10_RECIP) >> DIV10_SHIFT for n < 2^26
  localparam int DIV10_SHIFT = 27;
  localparam logic [MAC_A_W-1:0] DIV10_RECIP = 28'd13421773;
  localparam int CELL_SHIFT = 26;
  localparam int RECIP_W    = 27;

  localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};
  localparam logic [MV_W-1:0]   MV_MAX   = {MV_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_SCALE = 3'd0,
    REG_DIV_RATIO = 3'd1,
    REG_CAL       = 3'd2,
    REG_CELLS     = 3'd3,
    REG_WARN      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             sample_ok;
    logic [RAW_W-1:0] raw_count;
  } sample_t;

  typedef struct packed {
    logic             reading_valid;
    logic [MV_W-1:0]  pack_millivolts;
    logic [PCT_W-1:0] charge_percent;
    logic             low_warning;
  } reading_t;

  typedef struct packed {
    logic [SCALE_W-1:0] adc_scale_q16;
    logic [RATIO_W-1:0] divider_ratio_q8;
    logic [CAL_W-1:0]   calibration_q14;
    logic [CELL_W-1:0]  cell_count;
    logic [PCT_W-1:0]   warn_percent;
  } cfg_t;

  // acc <= base +/- a * b when en
  typedef struct packed {
    logic               en;
    logic               sub;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [ACC_W-1:0]   base;
  } mac_op_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // Per-cell curve voltage, 1/16 mV, descending
  function automatic logic [CURVE_V_W-1:0] curve_v(input logic [SEG_W-1:0] idx);
    logic [CURVE_V_W-1:0] v;
    case (idx)
      5'd0:  v = 17'd67200;
      5'd1:  v = 17'd66400;
      5'd2:  v = 17'd65760;
      5'd3:  v = 17'd65280;
      5'd4:  v = 17'd64320;
      5'd5:  v = 17'd63680;
      5'd6:  v = 17'd63200;
      5'd7:  v = 17'd62560;
      5'd8:  v = 17'd61920;
      5'd9:  v = 17'd61600;
      5'd10: v = 17'd61440;
      5'd11: v = 17'd61120;
      5'd12: v = 17'd60800;
      5'd13: v = 17'd60640;
      5'd14: v = 17'd60320;
      5'd15: v = 17'd60000;
      5'd16: v = 17'd59680;
      5'd17: v = 17'd59360;
      5'd18: v = 17'd59040;
      5'd19: v = 17'd57760;
      5'd20: v = 17'd52800;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_p(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] p;
    case (idx)
      5'd0:  p = 7'd100;
      5'd1:  p = 7'd95;
      5'd2:  p = 7'd90;
      5'd3:  p = 7'd85;
      5'd4:  p = 7'd80;
      5'd5:  p = 7'd75;
      5'd6:  p = 7'd70;
      5'd7:  p = 7'd65;
      5'd8:  p = 7'd60;
      5'd9:  p = 7'd55;
      5'd10: p = 7'd50;
      5'd11: p = 7'd45;
      5'd12: p = 7'd40;
      5'd13: p = 7'd35;
      5'd14: p = 7'd30;
      5'd15: p = 7'd25;
      5'd16: p = 7'd20;
      5'd17: p = 7'd15;
      5'd18: p = 7'd10;
      5'd19: p = 7'd5;
      default: p = '0;
    endcase
    return p;
  endfunction

  // ceil(2^26 / n); a count of zero is taken as one cell
  function automatic logic [RECIP_W-1:0] cell_recip(input logic [CELL_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      5'd0:  r = 27'd67108864;
      5'd1:  r = 27'd67108864;
      5'd2:  r = 27'd33554432;
      5'd3:  r = 27'd22369622;
      5'd4:  r = 27'd16777216;
      5'd5:  r = 27'd13421773;
      5'd6:  r = 27'd11184811;
      5'd7:  r = 27'd9586981;
      5'd8:  r = 27'd8388608;
      5'd9:  r = 27'd7456541;
      5'd10: r = 27'd6710887;
      5'd11: r = 27'd6100806;
      5'd12: r = 27'd5592406;
      5'd13: r = 27'd5162221;
      5'd14: r = 27'd4793491;
      5'd15: r = 27'd4473925;
      5'd16: r = 27'd4194304;
      5'd17: r = 27'd3947581;
      5'd18: r = 27'd3728271;
      5'd19: r = 27'd3532046;
      5'd20: r = 27'd3355444;
      5'd21: r = 27'd3195661;
      5'd22: r = 27'd3050403;
      5'd23: r = 27'd2917777;
      5'd24: r = 27'd2796203;
      5'd25: r = 27'd2684355;
      5'd26: r = 27'd2581111;
      5'd27: r = 27'd2485514;
      5'd28: r = 27'd2396746;
      5'd29: r = 27'd2314099;
      5'd30: r = 27'd2236963;
      default: r = 27'd2164803;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/bfg_mac.sv
// bfg_mac: the shared multiply-add unit, acc <= base +/- a * b, registered.
// Depends on bfg_pkg for widths and the operation struct.
module bfg_mac (
  input  logic                           clk,
  input  bfg_pkg::mac_op_t               op,
  output logic [bfg_pkg::ACC_W-1:0]      acc
);

  logic [bfg_pkg::MAC_A_W+bfg_pkg::MAC_B_W-1:0] prod;
  logic [bfg_pkg::ACC_W-1:0]                    prod_ext;

  assign prod     = op.a * op.b;
  assign prod_ext = bfg_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= op.sub ? (op.base - prod_ext) : (op.base + prod_ext);
    end
  end

endmodule

>>> rtl/bfg_seq.sv
// bfg_seq: sequencer for one gauge request; drives the shared multiply-add
// unit step by step, holds the filter and warning state. Depends on bfg_pkg.
module bfg_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  bfg_pkg::sample_t           sample,
  input  bfg_pkg::cfg_t              cfg,
  input  logic                       take,
  input  logic [bfg_pkg::ACC_W-1:0]  acc,
  output bfg_pkg::mac_op_t           op,
  output bfg_pkg::seq_stat_t         stat,
  output bfg_pkg::reading_t          reading
);

  localparam int ACC_W   = bfg_pkg::ACC_W;
  localparam int VOLT_W  = bfg_pkg::VOLT_W;
  localparam int SEG_W   = bfg_pkg::SEG_W;
  localparam int PCT_W   = bfg_pkg::PCT_W;
  localparam int Q_W     = bfg_pkg::Q_W;
  localparam int P1_W    = bfg_pkg::RAW_W + bfg_pkg::SCALE_W;   // raw * scale
  localparam int LO_W    = 24;                                  // split of a wide a-operand
  localparam int HALF_B  = bfg_pkg::MAC_B_W;                    // split of a wide b-operand
  localparam int T_LSB   = 20;
  localparam int T_W     = ACC_W - T_LSB;
  localparam int CAL_SH  = 14;
  localparam int N_W     = 25;                                  // 7*avg + 3*v + 5
  localparam int QT_W    = ACC_W - bfg_pkg::DIV10_SHIFT;
  localparam logic [bfg_pkg::MAC_B_W-1:0] EMA_OLD_WT = 16'd7;
  localparam logic [bfg_pkg::MAC_B_W-1:0] EMA_NEW_WT = 16'd3;
  localparam logic [ACC_W-1:0]            EMA_ROUND  = 52'd5;
  localparam logic [VOLT_W:0]             MV_ROUND   = 22'd8;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'b0000_0000_0000_0001,
    ST_MUL_RAW = 16'b0000_0000_0000_0010,
    ST_MR_HI   = 16'b0000_0000_0000_0100,
    ST_MR_LO   = 16'b0000_0000_0000_1000,
    ST_MC_HI   = 16'b0000_0000_0001_0000,
    ST_MC_LO   = 16'b0000_0000_0010_0000,
    ST_SAT     = 16'b0000_0000_0100_0000,
    ST_EMA_V   = 16'b0000_0000_1000_0000,
    ST_D10_HI  = 16'b0000_0001_0000_0000,
    ST_D10_LO  = 16'b0000_0010_0000_0000,
    ST_AVG     = 16'b0000_0100_0000_0000,
    ST_CELL_LO = 16'b0000_1000_0000_0000,
    ST_RANGE   = 16'b0001_0000_0000_0000,
    ST_SEARCH  = 16'b0010_0000_0000_0000,
    ST_QDIV    = 16'b0100_0000_0000_0000,
    ST_FINISH  = 16'b1000_0000_0000_0000
  } state_t;

  state_t                    state, state_next;
  logic [bfg_pkg::RAW_W-1:0] raw, raw_next;
  logic [P1_W-1:0]           tmp, tmp_next;
  logic [VOLT_W-1:0]         vreg, vreg_next;
  logic [VOLT_W-1:0]         avg, avg_next;
  logic [VOLT_W-1:0]         creg, creg_next;
  logic [SEG_W-1:0]          seg, seg_next;
  logic [Q_W-1:0]            q, q_next;
  logic [PCT_W-1:0]          pct, pct_next;
  logic                      res_ok, res_ok_next;
  logic                      have_average, have_average_next;
  logic                      was_low, was_low_next;
  logic                      reported_valid, reported_valid_next;

  logic [SEG_W-1:0]               seg_nx;
  logic [bfg_pkg::CURVE_V_W-1:0]  v_hi, v_lo;
  logic [bfg_pkg::DV_W-1:0]       dv;
  logic [bfg_pkg::DV_W:0]         two_dv;
  logic [PCT_W-1:0]               dp;
  logic [T_W-1:0]                 t_val;
  logic [VOLT_W-1:0]              v_sat, avg_new, cell_v;
  logic [QT_W-1:0]                quot;
  logic [PCT_W:0]                 pct_sum;
  logic [VOLT_W:0]                mv_rnd;
  logic [bfg_pkg::MV_W-1:0]       mv_sat;
  logic [bfg_pkg::RECIP_W-1:0]    recip;
  logic                           low_now;

  // segment between curve points seg and seg+1
  assign seg_nx = seg + SEG_W'(1);
  assign v_hi   = bfg_pkg::curve_v(seg);
  assign v_lo   = bfg_pkg::curve_v(seg_nx);
  assign dv     = bfg_pkg::DV_W'(v_hi - v_lo);
  assign two_dv = {dv, 1'b0};
  assign dp     = bfg_pkg::curve_p(seg) - bfg_pkg::curve_p(seg_nx);

  assign t_val  = acc[ACC_W-1:T_LSB];
  assign v_sat  = (|acc[ACC_W-1:CAL_SH+VOLT_W]) ? bfg_pkg::VOLT_MAX
                                                 : acc[CAL_SH+VOLT_W-1:CAL_SH];
  assign quot   = acc[ACC_W-1:bfg_pkg::DIV10_SHIFT];
  assign avg_new = (quot > QT_W'(bfg_pkg::VOLT_MAX)) ? bfg_pkg::VOLT_MAX
                                                     : quot[VOLT_W-1:0];
  assign cell_v = acc[bfg_pkg::CELL_SHIFT+VOLT_W-1:bfg_pkg::CELL_SHIFT];
  assign recip  = bfg_pkg::cell_recip(cfg.cell_count);
  assign pct_sum = {1'b0, bfg_pkg::curve_p(seg_nx)} + (PCT_W+1)'(q);

  always_comb begin
    state_next          = state;
    raw_next            = raw;
    tmp_next            = tmp;
    vreg_next           = vreg;
    avg_next            = avg;
    creg_next           = creg;
    seg_next            = seg;
    q_next              = q;
    pct_next            = pct;
    res_ok_next         = res_ok;
    have_average_next   = have_average;
    was_low_next        = was_low;
    reported_valid_next = reported_valid;
    op                  = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (sample.sample_ok) begin
            raw_next   = sample.raw_count;
            state_next = ST_MUL_RAW;
          end else if (reported_valid) begin
            res_ok_next = 1'b0;
            state_next  = ST_FINISH;
          end
        end
      end
      ST_MUL_RAW: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(cfg.adc_scale_q16);
        op.b       = bfg_pkg::MAC_B_W'(raw);
        state_next = ST_MR_HI;
      end
      ST_MR_HI: begin
        tmp_next   = acc[P1_W-1:0];
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(acc[P1_W-1:LO_W]);
        op.b       = bfg_pkg::MAC_B_W'(cfg.divider_ratio_q8);
        state_next = ST_MR_LO;
      end
      ST_MR_LO: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(tmp[LO_W-1:0]);
        op.b       = bfg_pkg::MAC_B_W'(cfg.divider_ratio_q8);
        op.base    = {acc[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
        state_next = ST_MC_HI;
      end
      ST_MC_HI: begin
        tmp_next   = P1_W'(t_val);
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(t_val[T_W-1:LO_W]);
        op.b       = bfg_pkg::MAC_B_W'(cfg.calibration_q14);
        state_next = ST_MC_LO;
      end
      ST_MC_LO: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(tmp[LO_W-1:0]);
        op.b       = bfg_pkg::MAC_B_W'(cfg.calibration_q14);
        op.base    = {acc[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
        state_next = ST_SAT;
      end
      ST_SAT: begin
        vreg_next = v_sat;
        op.en     = 1'b1;
        if (have_average) begin
          op.a       = bfg_pkg::MAC_A_W'(avg);
          op.b       = EMA_OLD_WT;
          op.base    = EMA_ROUND;
          state_next = ST_EMA_V;
        end else begin
          // first sample seeds the average
          avg_next          = v_sat;
          have_average_next = 1'b1;
          op.a              = bfg_pkg::MAC_A_W'(recip);
          op.b              = bfg_pkg::MAC_B_W'(v_sat[VOLT_W-1:HALF_B]);
          state_next        = ST_CELL_LO;
        end
      end
      ST_EMA_V: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(vreg);
        op.b       = EMA_NEW_WT;
        op.base    = acc;
        state_next = ST_D10_HI;
      end
      ST_D10_HI: begin
        tmp_next   = P1_W'(acc[N_W-1:0]);
        op.en      = 1'b1;
        op.a       = bfg_pkg::DIV10_RECIP;
        op.b       = bfg_pkg::MAC_B_W'(acc[N_W-1:HALF_B]);
        state_next = ST_D10_LO;
      end
      ST_D10_LO: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::DIV10_RECIP;
        op.b       = tmp[HALF_B-1:0];
        op.base    = {acc[ACC_W-HALF_B-1:0], {HALF_B{1'b0}}};
        state_next = ST_AVG;
      end
      ST_AVG: begin
        avg_next   = avg_new;
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(recip);
        op.b       = bfg_pkg::MAC_B_W'(avg_new[VOLT_W-1:HALF_B]);
        state_next = ST_CELL_LO;
      end
      ST_CELL_LO: begin
        op.en      = 1'b1;
        op.a       = bfg_pkg::MAC_A_W'(recip);
        op.b       = avg[HALF_B-1:0];
        op.base    = {acc[ACC_W-HALF_B-1:0], {HALF_B{1'b0}}};
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        creg_next   = cell_v;
        res_ok_next = 1'b1;
        if (cell_v >= VOLT_W'(bfg_pkg::curve_v('0))) begin
          pct_next   = bfg_pkg::PCT_MAX;
          state_next = ST_FINISH;
        end else if (cell_v <= VOLT_W'(bfg_pkg::curve_v(SEG_W'(bfg_pkg::CURVE_POINTS - 1))))
        begin
          pct_next   = '0;
          state_next = ST_FINISH;
        end else begin
          seg_next   = '0;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (creg > VOLT_W'(v_lo)) begin
          // numerator 2*(c - vlo)*dp + dv, quotient by 2*dv follows
          op.en      = 1'b1;
          op.a       = bfg_pkg::MAC_A_W'(creg - VOLT_W'(v_lo));
          op.b       = bfg_pkg::MAC_B_W'({dp, 1'b0});
          op.base    = ACC_W'(dv);
          q_next     = '0;
          state_next = ST_QDIV;
        end else begin
          seg_next = seg_nx;
        end
      end
      ST_QDIV: begin
        if (acc >= ACC_W'(two_dv)) begin
          op.en   = 1'b1;
          op.sub  = 1'b1;
          op.a    = bfg_pkg::MAC_A_W'(two_dv);
          op.b    = bfg_pkg::MAC_B_W'(1);
          op.base = acc;
          q_next  = q + Q_W'(1);
        end else begin
          pct_next   = (pct_sum > (PCT_W+1)'(bfg_pkg::PCT_MAX)) ? bfg_pkg::PCT_MAX
                                                                : pct_sum[PCT_W-1:0];
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (take) begin
          state_next = ST_IDLE;
          if (res_ok) begin
            was_low_next        = low_now;
            reported_valid_next = 1'b1;
          end else begin
            reported_valid_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      have_average   <= 1'b0;
      was_low        <= 1'b0;
      reported_valid <= 1'b0;
      res_ok         <= 1'b0;
    end else begin
      state          <= state_next;
      have_average   <= have_average_next;
      was_low        <= was_low_next;
      reported_valid <= reported_valid_next;
      res_ok         <= res_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    raw  <= raw_next;
    tmp  <= tmp_next;
    vreg <= vreg_next;
    avg  <= avg_next;
    creg <= creg_next;
    seg  <= seg_next;
    q    <= q_next;
    pct  <= pct_next;
  end

  // (avg + 8) >> 4, saturated
  assign mv_rnd  = {1'b0, avg} + MV_ROUND;
  assign mv_sat  = mv_rnd[VOLT_W:4] > (VOLT_W-3)'(bfg_pkg::MV_MAX) ? bfg_pkg::MV_MAX
                                                                  : mv_rnd[bfg_pkg::MV_W+3:4];
  assign low_now = pct <= cfg.warn_percent;

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_FINISH);

  assign reading.reading_valid   = res_ok;
  assign reading.pack_millivolts = res_ok ? mv_sat : '0;
  assign reading.charge_percent  = res_ok ? pct : '0;
  assign reading.low_warning     = res_ok & low_now & ~was_low;

endmodule

>>> rtl/battery_fuel_gauge_unit.sv
// battery_fuel_gauge_unit: top level; configuration registers, input and
// output handshakes, result register. Uses bfg_pkg, bfg_mac and bfg_seq.
//
//   channel   dir  handshake                    payload
//   sample    in   sample_valid / sample_stall  bfg_pkg::sample_t
//   result    out  result_valid / result_stall  bfg_pkg::reading_t
//   cfg       in   cfg_write                    cfg_index, cfg_data
//
// A good sample is loaded after 7 multiply-add steps, range check and hand-off,
// with 4 more steps once the average is seeded, up to 20 curve segment checks
// and 6 quotient steps, all on one multiplier. A failed read goes straight to
// hand-off only if the last result was valid, else it gives no result. One request is in flight;
// the next is taken once the result is in the output register, even if stalled.
// Reset is synchronous and restores the register defaults; no clearing pass.
module battery_fuel_gauge_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  bfg_pkg::sample_t                  sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bfg_pkg::reading_t                 result,
  input  logic                              cfg_write,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bfg_pkg::cfg_t              cfg;
  bfg_pkg::mac_op_t           op;
  bfg_pkg::seq_stat_t         stat;
  bfg_pkg::reading_t          reading;
  logic [bfg_pkg::ACC_W-1:0]  acc;
  logic                       start;
  logic                       take;

  assign sample_stall = ~stat.idle;
  assign start        = sample_valid & ~sample_stall;
  assign take         = stat.done & (~result_valid | ~result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_scale_q16    <= 24'd28800;
      cfg.divider_ratio_q8 <= 16'd2355;
      cfg.calibration_q14  <= 15'd16384;
      cfg.cell_count       <= 5'd1;
      cfg.warn_percent     <= 7'd20;
    end else if (cfg_write) begin
      unique case (bfg_pkg::cfg_reg_t'(cfg_index))
        bfg_pkg::REG_ADC_SCALE: cfg.adc_scale_q16    <= cfg_data[bfg_pkg::SCALE_W-1:0];
        bfg_pkg::REG_DIV_RATIO: cfg.divider_ratio_q8 <= cfg_data[bfg_pkg::RATIO_W-1:0];
        bfg_pkg::REG_CAL:       cfg.calibration_q14  <= cfg_data[bfg_pkg::CAL_W-1:0];
        bfg_pkg::REG_CELLS:     cfg.cell_count       <= cfg_data[bfg_pkg::CELL_W-1:0];
        bfg_pkg::REG_WARN:      cfg.warn_percent     <= cfg_data[bfg_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  bfg_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  bfg_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .sample  (sample),
    .cfg     (cfg),
    .take    (take),
    .acc     (acc),
    .op      (op),
    .stat    (stat),
    .reading (reading)
  );

  // output register: holds a finished result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= reading;
    end
  end

  // a good sample always starts the engine; a silent failed read does not
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sample.sample_ok |=> sample_stall)
    else $error("engine accepted a request without going busy");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.reading_valid |->
      result.pack_millivolts == '0 && result.charge_percent == '0 && !result.low_warning)
    else $error("invalid reading carries a non-zero payload");

  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.charge_percent <= bfg_pkg::PCT_MAX)
    else $error("charge percent above 100");

endmodule
